/* hdl/c2p_pkg.sv */
// ----------------------------------------------------------------------------
// c2p_pkg: shared constants for the cartesian to polar converter
// Widths, CORDIC arctangent table and magnitude saturation limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c2p_pkg;

  // Default configuration
  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int COORD_WIDTH_DEF       = 16;

  // Fixed field widths
  localparam int MAG_W   = 16;
  localparam int ANGLE_W = 16;
  localparam int THR_W   = 16;

  // CORDIC fixed point: coordinates are scaled up by 2^GUARD_BITS
  localparam int GUARD_BITS   = 24;
  localparam int Z_W          = 33;
  localparam int ATAN_ENTRIES = 24;

  // Angle accumulator is in 2^-32 turns; the output keeps the top 16 bits
  localparam int ANGLE_SHIFT = 16;
  localparam logic [Z_W-1:0] ANGLE_ROUND = Z_W'(32768);
  localparam logic [ANGLE_W-1:0] HALF_TURN = 16'h8000;

  // Square root works on a 32-bit radicand, one result bit per step
  localparam int RAD_W      = 32;
  localparam int ROOT_STEPS = 16;

  // Rounded root exceeds MAG_MAX exactly when the radicand exceeds
  // MAG_MAX * (MAG_MAX + 1)
  localparam logic [MAG_W-1:0] MAG_MAX  = 16'd46341;
  localparam logic [63:0]      SQ_LIMIT = 64'd2147534622;

  // Reset value of the origin threshold
  localparam logic [THR_W-1:0] THR_RESET = 16'd1;

  // round(atan(2^-i) * 2^32 / 2pi)
  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

`default_nettype wire

/* hdl/cartesian_to_polar_unit.sv */
// ----------------------------------------------------------------------------
// cartesian_to_polar_unit: streaming cartesian to polar converter
// Throughput: one point per cycle while the output skid is empty; each iteration
// stage holds at most one CORDIC rotation and one square root digit, so the longer of the two sets depth.
// Reset (rst_n, synchronous): pipeline and skid emptied, threshold = 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_polar_unit
  import c2p_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
  parameter int COORD_WIDTH       = COORD_WIDTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // configuration: origin_threshold
  input  wire                                  cfg_wr_en,
  input  wire  [THR_W-1:0]                     cfg_wr_data,
  // input beats: tdata = {y_coord, x_coord}, x_coord in the low bits
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [((2*COORD_WIDTH+7)/8)*8-1:0]   in_tdata,
  // result beats: tdata = {angle_turns, magnitude}, magnitude low
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [MAG_W+ANGLE_W-1:0]             out_tdata,
  // tuser: at_origin
  output logic [0:0]                           out_tuser
);

  localparam int CW    = COORD_WIDTH;
  localparam int NS    = (CORDIC_ITERATIONS > ROOT_STEPS) ? CORDIC_ITERATIONS : ROOT_STEPS;
  localparam int LAST  = NS + 3;
  localparam int SQ_W  = 2 * CW;
  localparam int XY_W  = CW + GUARD_BITS + 3;
  localparam int XY_PAD = XY_W - CW - GUARD_BITS;
  localparam int SUM_W = CW + 1;
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  // quadrant codes on {x negative, y negative}
  localparam logic [1:0] QUAD_I   = 2'b00;
  localparam logic [1:0] QUAD_II  = 2'b10;
  localparam logic [1:0] QUAD_III = 2'b11;
  localparam logic [1:0] QUAD_IV  = 2'b01;

  typedef struct packed {
    logic signed [XY_W-1:0] xc;
    logic signed [XY_W-1:0] yc;
    logic signed [Z_W-1:0]  zc;
    logic [RAD_W-1:0]       rem;
    logic [RAD_W-1:0]       root;
    logic                   sat;
    logic                   origin;
    logic                   zero;
    logic                   xneg;
    logic                   yneg;
  } iter_t;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: all stages advance together unless the skid is full
  // --------------------------------------------------------------------------
  logic            adv;
  logic [LAST:0]   vld_r;
  logic            skid_vld_r;

  assign adv       = !skid_vld_r;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:0], in_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: unpack and take absolute values
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] x_in;
  logic signed [CW-1:0] y_in;
  logic [CW-1:0]        ax0_nxt;
  logic [CW-1:0]        ay0_nxt;
  logic [CW-1:0]        ax0_r;
  logic [CW-1:0]        ay0_r;
  logic                 xneg0_r;
  logic                 yneg0_r;

  assign x_in    = in_tdata[CW-1:0];
  assign y_in    = in_tdata[2*CW-1:CW];
  assign ax0_nxt = x_in[CW-1] ? (~x_in + 1'b1) : x_in;
  assign ay0_nxt = y_in[CW-1] ? (~y_in + 1'b1) : y_in;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax0_r   <= ax0_nxt;
      ay0_r   <= ay0_nxt;
      xneg0_r <= x_in[CW-1];
      yneg0_r <= y_in[CW-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: squares and |x| + |y|
  // --------------------------------------------------------------------------
  logic [CW-1:0]    ax1_r;
  logic [CW-1:0]    ay1_r;
  logic [SQ_W-1:0]  axsq1_r;
  logic [SQ_W-1:0]  aysq1_r;
  logic [SUM_W-1:0] sum1_r;
  logic             xneg1_r;
  logic             yneg1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1_r   <= ax0_r;
      ay1_r   <= ay0_r;
      axsq1_r <= SQ_W'(ax0_r) * SQ_W'(ax0_r);
      aysq1_r <= SQ_W'(ay0_r) * SQ_W'(ay0_r);
      sum1_r  <= SUM_W'(ax0_r) + SUM_W'(ay0_r);
      xneg1_r <= xneg0_r;
      yneg1_r <= yneg0_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: radicand, saturation and origin checks, CORDIC start vector
  // --------------------------------------------------------------------------
  iter_t           it_r [NS+1];
  iter_t           init_nxt;
  logic [SQ_W-1:0] sq2;
  logic [63:0]     sq2_ext;

  always_comb begin
    sq2             = axsq1_r + aysq1_r;
    sq2_ext         = 64'(sq2);
    init_nxt.sat    = sq2_ext > SQ_LIMIT;
    init_nxt.rem    = init_nxt.sat ? '0 : sq2_ext[RAD_W-1:0];
    init_nxt.root   = '0;
    init_nxt.origin = CMP_W'(sum1_r) < CMP_W'(thr_r);
    init_nxt.zero   = (sum1_r == '0);
    init_nxt.xc     = $signed({{XY_PAD{1'b0}}, ax1_r, {GUARD_BITS{1'b0}}});
    init_nxt.yc     = $signed({{XY_PAD{1'b0}}, ay1_r, {GUARD_BITS{1'b0}}});
    init_nxt.zc     = '0;
    init_nxt.xneg   = xneg1_r;
    init_nxt.yneg   = yneg1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_r[0] <= init_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3 .. NS+2: at most one CORDIC rotation and one root digit per stage
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < NS; j++) begin : g_iter
    iter_t it_nxt;

    always_comb begin
      it_nxt = it_r[j];

      // vectoring rotation toward the x axis
      if (j < CORDIC_ITERATIONS) begin
        if (!it_r[j].yc[XY_W-1]) begin
          it_nxt.xc = it_r[j].xc + (it_r[j].yc >>> j);
          it_nxt.yc = it_r[j].yc - (it_r[j].xc >>> j);
          it_nxt.zc = it_r[j].zc + $signed(Z_W'(ATAN_TURNS[j]));
        end else begin
          it_nxt.xc = it_r[j].xc - (it_r[j].yc >>> j);
          it_nxt.yc = it_r[j].yc + (it_r[j].xc >>> j);
          it_nxt.zc = it_r[j].zc - $signed(Z_W'(ATAN_TURNS[j]));
        end
      end

      // restoring square root digit
      if (j < ROOT_STEPS) begin
        logic [RAD_W:0] trial;
        trial = {1'b0, it_r[j].root} + ((RAD_W+1)'(1) << (RAD_W - 2 - 2 * j));
        if ({1'b0, it_r[j].rem} >= trial) begin
          it_nxt.rem  = it_r[j].rem - trial[RAD_W-1:0];
          it_nxt.root = (it_r[j].root >> 1) + (RAD_W'(1) << (RAD_W - 2 - 2 * j));
        end else begin
          it_nxt.root = it_r[j].root >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        it_r[j+1] <= it_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Last stage: round and saturate the root; zero the angle at the origin, else map it to its quadrant
  // --------------------------------------------------------------------------
  iter_t              fin;
  logic [Z_W-1:0]     zq;
  logic [ANGLE_W-1:0] q16;
  logic [ANGLE_W-1:0] ang_nxt;
  logic [MAG_W-1:0]   mag_nxt;
  logic [RAD_W-1:0]   root_rnd;
  logic [MAG_W-1:0]   mag_r;
  logic [ANGLE_W-1:0] ang_r;
  logic               org_r;

  assign fin = it_r[NS];

  always_comb begin
    zq       = fin.zc + ANGLE_ROUND;
    q16      = zq[ANGLE_SHIFT+ANGLE_W-1:ANGLE_SHIFT];
    root_rnd = (fin.rem > fin.root) ? fin.root + 1'b1 : fin.root;
    mag_nxt  = fin.sat ? MAG_MAX : root_rnd[MAG_W-1:0];

    unique case ({fin.xneg, fin.yneg})
      QUAD_I:   ang_nxt = q16;
      QUAD_II:  ang_nxt = HALF_TURN - q16;
      QUAD_III: ang_nxt = HALF_TURN + q16;
      QUAD_IV:  ang_nxt = '0 - q16;
      default:  ang_nxt = q16;
    endcase

    if (fin.origin || fin.zero) begin
      ang_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r <= mag_nxt;
      ang_r <= ang_nxt;
      org_r <= fin.origin;
    end
  end

  // --------------------------------------------------------------------------
  // Output skid: parks the last-stage beat when the sink stalls
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0]   skid_mag_r;
  logic [ANGLE_W-1:0] skid_ang_r;
  logic               skid_org_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (vld_r[LAST] && !out_tready) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r) begin
      skid_mag_r <= mag_r;
      skid_ang_r <= ang_r;
      skid_org_r <= org_r;
    end
  end

  assign out_tvalid   = skid_vld_r || vld_r[LAST];
  assign out_tdata    = skid_vld_r ? {skid_ang_r, skid_mag_r} : {ang_r, mag_r};
  assign out_tuser[0] = skid_vld_r ? skid_org_r : org_r;

endmodule

`default_nettype wire
